// ===== sv/dcq_pkg.sv =====
package dcq_pkg;

   // fixed field widths
   localparam int SLOT_W      = 9;
   localparam int VALUE_W     = 8;
   localparam int INDEX_W     = 5;
   localparam int CTRL_BLK_W  = 4;
   localparam int MIN_SUM_W   = 10;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 10;

   // history row: four bytes, newest in the low byte
   localparam int HIST_DEPTH = 4;
   localparam int HIST_W     = HIST_DEPTH * VALUE_W;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CONTROL_BLOCK  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_CHANGE_SUM = 1'b1;

   // register reset values
   localparam logic [CTRL_BLK_W-1:0] CTRL_BLK_RESET = 4'd11;
   localparam logic [MIN_SUM_W-1:0]  MIN_SUM_RESET  = 10'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SPLIT,
      ST_SHIFT,
      ST_EVAL_RD,
      ST_EVAL_WR,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

endpackage

// ===== sv/dcq_req_if.sv =====
interface dcq_req_if;
   import dcq_pkg::*;

   logic               valid;
   logic               ready;
   logic [SLOT_W-1:0]  slot;
   logic [VALUE_W-1:0] slot_value;
   logic               frame_end;

   modport source (output valid, output slot, output slot_value, output frame_end,
                   input ready);
   modport sink   (input valid, input slot, input slot_value, input frame_end,
                   output ready);
endinterface

// ===== sv/dcq_rsp_if.sv =====
interface dcq_rsp_if;
   import dcq_pkg::*;

   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] out_index;
   logic [VALUE_W-1:0] out_value;
   logic               out_last;

   modport source (output valid, output out_index, output out_value, output out_last,
                   input ready);
   modport sink   (input valid, input out_index, input out_value, input out_last,
                   output ready);
endinterface

// ===== sv/dcq_ram.sv =====
module dcq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [WIDTH-1:0] rd_data_ff;
   logic             rd_vld_ff;

   // storage array and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   // per-entry valid bits, cleared by reset so unwritten entries read zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;
endmodule

// ===== sv/dcq_slot_split.sv =====
module dcq_slot_split #(
   parameter int CHANNELS_PER_BLOCK = 16
) (
   input  logic                                  clock,
   input  logic [dcq_pkg::SLOT_W-1:0]            pos,
   output logic [dcq_pkg::SLOT_W-1:0]            blk,
   output logic [$clog2(CHANNELS_PER_BLOCK)-1:0] ch
);
   import dcq_pkg::*;

   localparam int CH_W      = $clog2(CHANNELS_PER_BLOCK);
   localparam int DIV_SHIFT = 18;
   localparam int PROD_W    = SLOT_W + DIV_SHIFT;
   localparam logic [DIV_SHIFT-1:0] DIV_MULT =
      DIV_SHIFT'((1 << DIV_SHIFT) / CHANNELS_PER_BLOCK + 1);
   localparam logic [SLOT_W:0] CPB_W = (SLOT_W + 1)'(CHANNELS_PER_BLOCK);

   logic [PROD_W-1:0] prod;
   logic [SLOT_W-1:0] quot_ff;
   logic [SLOT_W:0]   back;
   logic [SLOT_W:0]   rem_raw;
   logic [SLOT_W:0]   rem;

   // quotient estimate by reciprocal multiply
   assign prod = PROD_W'(pos) * PROD_W'(DIV_MULT);

   always_ff @(posedge clock) begin
      quot_ff <= prod[PROD_W-1:DIV_SHIFT];
   end

   // remainder and one-step correction
   assign back    = (SLOT_W + 1)'(quot_ff) * CPB_W;
   assign rem_raw = {1'b0, pos} - back;

   always_comb begin
      if (rem_raw >= CPB_W) begin
         blk = quot_ff + SLOT_W'(1);
         rem = rem_raw - CPB_W;
      end else begin
         blk = quot_ff;
         rem = rem_raw;
      end
   end

   assign ch = rem[CH_W-1:0];
endmodule

// ===== sv/dmx_channel_qualifier.sv =====
// slot beat: taken in idle, then slot decode; in the control block the history row
//   is read, then the shifted row is written back through the history ram
// frame end beat: then evaluation of each channel (held ram read and write per
//   channel), then a read and an output step per report beat, held by any rsp stall
// slot beats are taken only in idle, so a new one waits until the last one and any report are done
// reset: synchronous; histories and held values read as zero, registers to 11 and 2
module dmx_channel_qualifier #(
   parameter int CHANNELS_PER_BLOCK = 16,
   parameter int ACTIVE_BLOCKS      = 6,
   parameter int NUM_BLOCKS         = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   dcq_req_if.sink                          req_ch,
   dcq_rsp_if.source                        rsp_ch,
   input  logic                             csr_write_en,
   input  logic [dcq_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dcq_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dcq_pkg::*;

   localparam int CH_W       = $clog2(CHANNELS_PER_BLOCK);
   localparam int REPORT_LEN = CHANNELS_PER_BLOCK + ACTIVE_BLOCKS;
   localparam int IDX_W      = $clog2(REPORT_LEN);
   localparam logic [SLOT_W:0]  SLOT_LIMIT = (SLOT_W + 1)'(NUM_BLOCKS * CHANNELS_PER_BLOCK);
   localparam logic [CH_W-1:0]  HALF       = CH_W'(CHANNELS_PER_BLOCK / 2);
   localparam logic [CH_W-1:0]  LAST_CH    = CH_W'(CHANNELS_PER_BLOCK - 1);
   localparam logic [IDX_W-1:0] HELD_END   = IDX_W'(CHANNELS_PER_BLOCK);
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(REPORT_LEN - 1);

   function automatic logic [VALUE_W-1:0] absdiff(input logic [VALUE_W-1:0] a,
                                                   input logic [VALUE_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   state_type state_ff, state_in;

   logic [SLOT_W-1:0]        pos_ff, pos_in;
   logic [VALUE_W-1:0]       val_ff, val_in;
   logic                     fend_ff, fend_in;
   logic                     in_range_ff, in_range_in;
   logic [CTRL_BLK_W-1:0]    ctrl_blk_ff, ctrl_blk_in;
   logic [MIN_SUM_W-1:0]     min_sum_ff, min_sum_in;
   logic [ACTIVE_BLOCKS-1:0] frame_act_ff, frame_act_in;
   logic [ACTIVE_BLOCKS-1:0] block_act_ff, block_act_in;
   logic [CH_W-1:0]          chan_ff, chan_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;

   logic [SLOT_W-1:0]        split_blk;
   logic [CH_W-1:0]          split_ch;
   logic                     hit;
   logic [ACTIVE_BLOCKS-1:0] act_set;

   logic              hist_rd_en, hist_wr_en;
   logic [CH_W-1:0]   hist_rd_addr, hist_wr_addr;
   logic [HIST_W-1:0] hist_rd_data, hist_wr_data;
   logic               held_rd_en, held_wr_en;
   logic [CH_W-1:0]    held_rd_addr;
   logic [VALUE_W-1:0] held_rd_data;

   logic [VALUE_W-1:0]   h0, h1, h2, h3;
   logic [MIN_SUM_W-1:0] step_sum;
   logic                 three, differs, take;
   logic [CH_W-1:0]      partner;
   logic                 is_held, flag, is_last;
   logic                 req_beat, rsp_beat;

   assign req_beat = req_ch.valid && req_ch.ready;
   assign rsp_beat = rsp_ch.valid && rsp_ch.ready;

   // slot number to block and channel
   dcq_slot_split #(
      .CHANNELS_PER_BLOCK (CHANNELS_PER_BLOCK)
   ) u_split (
      .clock (clock),
      .pos   (pos_ff),
      .blk   (split_blk),
      .ch    (split_ch)
   );

   assign hit = in_range_ff && (split_blk == SLOT_W'(ctrl_blk_ff));

   always_comb begin
      for (int i = 0; i < ACTIVE_BLOCKS; i++) begin
         act_set[i] = (split_blk == SLOT_W'(i)) && (val_ff != '0);
      end
   end

   // four-byte history per control channel
   dcq_ram #(
      .WIDTH (HIST_W),
      .DEPTH (CHANNELS_PER_BLOCK)
   ) u_hist_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (hist_wr_en),
      .wr_addr (hist_wr_addr),
      .wr_data (hist_wr_data),
      .rd_en   (hist_rd_en),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   // held channel values
   dcq_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CHANNELS_PER_BLOCK)
   ) u_held_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (held_wr_en),
      .wr_addr (chan_ff),
      .wr_data (h0),
      .rd_en   (held_rd_en),
      .rd_addr (held_rd_addr),
      .rd_data (held_rd_data)
   );

   // qualification of one channel from its history row
   assign h0 = hist_rd_data[VALUE_W-1:0];
   assign h1 = hist_rd_data[2*VALUE_W-1:VALUE_W];
   assign h2 = hist_rd_data[3*VALUE_W-1:2*VALUE_W];
   assign h3 = hist_rd_data[4*VALUE_W-1:3*VALUE_W];

   assign step_sum = MIN_SUM_W'(absdiff(h3, h2)) + MIN_SUM_W'(absdiff(h2, h1))
                   + MIN_SUM_W'(absdiff(h1, h0));
   assign three    = (h3 != h2) && (h2 != h1) && (h1 != h0);
   assign differs  = (h0 != held_rd_data) && (h1 != h0);
   assign take     = (three || differs) && (step_sum > min_sum_ff);
   assign partner  = (chan_ff < HALF) ? chan_ff + HALF : chan_ff - HALF;

   // report beat fields
   assign is_held = idx_ff < HELD_END;
   assign is_last = idx_ff == LAST_IDX;

   always_comb begin
      flag = 1'b0;
      for (int i = 0; i < ACTIVE_BLOCKS; i++) begin
         if (idx_ff == IDX_W'(CHANNELS_PER_BLOCK + i)) begin
            flag = block_act_ff[i];
         end
      end
   end

   assign rsp_ch.out_index = INDEX_W'(idx_ff);
   assign rsp_ch.out_value = is_held ? held_rd_data : VALUE_W'(flag);
   assign rsp_ch.out_last  = is_last;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            state_in = ST_SPLIT;
         end
         ST_SPLIT: begin
            priority if (hit) begin
               state_in = ST_SHIFT;
            end else if (fend_ff) begin
               state_in = ST_EVAL_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SHIFT: begin
            state_in = fend_ff ? ST_EVAL_RD : ST_IDLE;
         end
         ST_EVAL_RD: begin
            state_in = ST_EVAL_WR;
         end
         ST_EVAL_WR: begin
            state_in = (chan_ff == LAST_CH) ? ST_EMIT_RD : ST_EVAL_RD;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (rsp_beat) begin
               state_in = is_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and memory controls
   always_comb begin
      req_ch.ready = 1'b0;
      rsp_ch.valid = 1'b0;
      hist_rd_en   = 1'b0;
      hist_rd_addr = chan_ff;
      hist_wr_en   = 1'b0;
      hist_wr_addr = split_ch;
      hist_wr_data = {hist_rd_data[HIST_W-VALUE_W-1:0], val_ff};
      held_rd_en   = 1'b0;
      held_rd_addr = idx_ff[CH_W-1:0];
      held_wr_en   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
         end
         ST_SPLIT: begin
            hist_rd_en   = hit;
            hist_rd_addr = split_ch;
         end
         ST_SHIFT: begin
            hist_wr_en = 1'b1;
         end
         ST_EVAL_RD: begin
            hist_rd_en   = 1'b1;
            held_rd_en   = 1'b1;
            held_rd_addr = partner;
         end
         ST_EVAL_WR: begin
            held_wr_en = take;
         end
         ST_EMIT_RD: begin
            held_rd_en = is_held;
         end
         ST_EMIT_OUT: begin
            rsp_ch.valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      pos_in       = pos_ff;
      val_in       = val_ff;
      fend_in      = fend_ff;
      in_range_in  = in_range_ff;
      ctrl_blk_in  = ctrl_blk_ff;
      min_sum_in   = min_sum_ff;
      frame_act_in = frame_act_ff;
      block_act_in = block_act_ff;
      chan_in      = chan_ff;
      idx_in       = idx_ff;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_CONTROL_BLOCK:  ctrl_blk_in = csr_wdata[CTRL_BLK_W-1:0];
            CSR_MIN_CHANGE_SUM: min_sum_in  = csr_wdata[MIN_SUM_W-1:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            chan_in = '0;
            if (req_beat) begin
               pos_in      = req_ch.slot - SLOT_W'(1);
               val_in      = req_ch.slot_value;
               fend_in     = req_ch.frame_end;
               in_range_in = (req_ch.slot != '0) && ({1'b0, req_ch.slot} <= SLOT_LIMIT);
            end
         end
         ST_SPLIT: begin
            if (in_range_ff) begin
               frame_act_in = frame_act_ff | act_set;
            end
         end
         ST_EVAL_WR: begin
            chan_in = chan_ff + CH_W'(1);
            if (chan_ff == LAST_CH) begin
               block_act_in = frame_act_ff;
               frame_act_in = '0;
               idx_in       = '0;
            end
         end
         ST_EMIT_OUT: begin
            if (rsp_beat) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      val_ff      <= val_in;
      fend_ff     <= fend_in;
      in_range_ff <= in_range_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ctrl_blk_ff  <= CTRL_BLK_RESET;
         min_sum_ff   <= MIN_SUM_RESET;
         frame_act_ff <= '0;
         block_act_ff <= '0;
         chan_ff      <= '0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         ctrl_blk_ff  <= ctrl_blk_in;
         min_sum_ff   <= min_sum_in;
         frame_act_ff <= frame_act_in;
         block_act_ff <= block_act_in;
         chan_ff      <= chan_in;
         idx_ff       <= idx_in;
      end
   end
endmodule

// ===== sv/dcq_checker.sv =====
module dcq_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_frame_end,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [dcq_pkg::INDEX_W-1:0] rsp_out_index,
   input logic [dcq_pkg::VALUE_W-1:0] rsp_out_value,
   input logic                        rsp_out_last
);
   import dcq_pkg::*;

   // a stalled report beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_index)
         && $stable(rsp_out_value) && $stable(rsp_out_last))
      else $error("report beat changed while stalled");

   // no slot beat is taken while a report is in progress
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid)
      else $error("slot beat accepted during report");

   // a slot beat without frame end produces no report beat
   a_quiet_slot: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_frame_end |=> !rsp_valid)
      else $error("report beat after a plain slot beat");

   // report beats are spaced: nothing presented right after a taken beat
   a_beat_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("report beat directly after a taken beat");

   // reset leaves no report pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("report beat right after reset");
endmodule

bind dmx_channel_qualifier dcq_checker u_dcq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .req_frame_end (req_ch.frame_end),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_out_index (rsp_ch.out_index),
   .rsp_out_value (rsp_ch.out_value),
   .rsp_out_last  (rsp_ch.out_last)
);

// ===== tb/sv/tb_dmx_channel_qualifier.sv =====
module tb_dmx_channel_qualifier;
   timeunit 1ns;
   timeprecision 1ps;

   import dcq_pkg::*;

   localparam int CHANNELS      = 16;
   localparam int ACTIVE_BLOCKS = 6;
   localparam int NUM_BLOCKS    = 12;
   localparam int SETTLE_CYCLES = 16;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [VALUE_W-1:0] value;
      logic               last;
   } report_t;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   dcq_req_if req ();
   dcq_rsp_if rsp ();

   dmx_channel_qualifier uut (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req),
      .rsp_ch       (rsp),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // predicted block state
   logic [VALUE_W-1:0]    slot_hist [CHANNELS][HIST_DEPTH];
   logic [VALUE_W-1:0]    held_level [CHANNELS];
   logic [ACTIVE_BLOCKS-1:0] frame_act;
   logic [CTRL_BLK_W-1:0] ctrl_blk;
   logic [MIN_SUM_W-1:0]  min_sum;

   report_t report_q [$];
   int      mismatch_count = 0;
   int      gap_pct;
   int      stall_pct;

   always #2 clock = ~clock;

   function automatic int step_size(logic [VALUE_W-1:0] a, logic [VALUE_W-1:0] b);
      return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
   endfunction

   // take one slot beat into the predicted state, queue the frame report on frame end
   function automatic void qualify_slot(logic [SLOT_W-1:0] s, logic [VALUE_W-1:0] v,
                                        logic fe);
      int unsigned pos;
      int unsigned blk;
      int unsigned ch;
      int unsigned partner;
      int          sum;
      logic        three;
      logic        differs;
      report_t     beat;
      if (s != 0 && s <= NUM_BLOCKS * CHANNELS) begin
         pos = s - 1;
         blk = pos / CHANNELS;
         ch  = pos % CHANNELS;
         if (blk < ACTIVE_BLOCKS && v != 0) frame_act[blk] = 1'b1;
         if (blk == ctrl_blk) begin
            for (int d = HIST_DEPTH - 1; d > 0; d--) slot_hist[ch][d] = slot_hist[ch][d-1];
            slot_hist[ch][0] = v;
         end
      end
      if (!fe) return;
      // channels in ascending order, later ones see updated partners
      for (int j = 0; j < CHANNELS; j++) begin
         partner = (j < CHANNELS / 2) ? j + CHANNELS / 2 : j - CHANNELS / 2;
         sum = step_size(slot_hist[j][3], slot_hist[j][2]) +
               step_size(slot_hist[j][2], slot_hist[j][1]) +
               step_size(slot_hist[j][1], slot_hist[j][0]);
         three = (slot_hist[j][3] != slot_hist[j][2]) &&
                 (slot_hist[j][2] != slot_hist[j][1]) &&
                 (slot_hist[j][1] != slot_hist[j][0]);
         differs = (slot_hist[j][0] != held_level[partner]) &&
                   (slot_hist[j][1] != slot_hist[j][0]);
         if ((three || differs) && sum > int'(min_sum)) held_level[j] = slot_hist[j][0];
      end
      for (int j = 0; j < CHANNELS; j++) begin
         beat.index = INDEX_W'(j);
         beat.value = held_level[j];
         beat.last  = 1'b0;
         report_q.push_back(beat);
      end
      for (int b = 0; b < ACTIVE_BLOCKS; b++) begin
         beat.index = INDEX_W'(CHANNELS + b);
         beat.value = VALUE_W'(frame_act[b]);
         beat.last  = (b == ACTIVE_BLOCKS - 1);
         report_q.push_back(beat);
      end
      frame_act = '0;
   endfunction

   // sender: optional idle gap, then hold the beat until accepted
   task automatic send_slot(input logic [SLOT_W-1:0] s, input logic [VALUE_W-1:0] v,
                            input logic fe);
      if ($urandom_range(99) < gap_pct) begin
         req.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req.valid      <= 1'b1;
      req.slot       <= s;
      req.slot_value <= v;
      req.frame_end  <= fe;
      do @(posedge clock); while (!req.ready);
      qualify_slot(s, v, fe);
   endtask

   task automatic end_burst();
      req.valid <= 1'b0;
   endtask

   // wait for the report queue to empty, then let the block settle
   task automatic drain();
      while (report_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_CONTROL_BLOCK) ctrl_blk = data[CTRL_BLK_W-1:0];
      else if (idx == CSR_MIN_CHANGE_SUM) min_sum = data[MIN_SUM_W-1:0];
      @(posedge clock);
   endtask

   // receiver stall and result checking
   always @(posedge clock) begin
      report_t want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (report_q.size() == 0) begin
            $error("unexpected report beat: out_index %0d out_value %0d",
                   rsp.out_index, rsp.out_value);
            mismatch_count++;
         end else begin
            want = report_q.pop_front();
            if (rsp.out_index !== want.index) begin
               $error("out_index expected %0d got %0d", want.index, rsp.out_index);
               mismatch_count++;
            end
            if (rsp.out_value !== want.value) begin
               $error("out_value expected %0d got %0d", want.value, rsp.out_value);
               mismatch_count++;
            end
            if (rsp.out_last !== want.last) begin
               $error("out_last expected %0d got %0d", want.last, rsp.out_last);
               mismatch_count++;
            end
         end
      end
      rsp.ready <= ($urandom_range(99) >= stall_pct);
   end

   // start code only: report of the reset state
   task automatic test_start_code_report();
      send_slot(9'd0, 8'd255, 1'b1);
      end_burst();
      drain();
   endtask

   // slot decode with reset registers: repeats, empty slots, out of range slots
   task automatic test_slot_decode();
      send_slot(9'd177, 8'd10, 1'b0);
      send_slot(9'd177, 8'd20, 1'b0);
      send_slot(9'd177, 8'd30, 1'b0);
      send_slot(9'd1, 8'd0, 1'b0);
      send_slot(9'd16, 8'd1, 1'b0);
      send_slot(9'd96, 8'd255, 1'b0);
      send_slot(9'd193, 8'd7, 1'b0);
      send_slot(9'd256, 8'd1, 1'b0);
      send_slot(9'd511, 8'd255, 1'b0);
      send_slot(9'd192, 8'd255, 1'b1);
      end_burst();
      drain();
   endtask

   // threshold at its top and bottom, control block in and out of range
   task automatic test_threshold_extremes();
      write_reg(CSR_CONTROL_BLOCK, 10'd0);
      write_reg(CSR_MIN_CHANGE_SUM, 10'd765);
      send_slot(9'd1, 8'd255, 1'b0);
      send_slot(9'd1, 8'd0, 1'b0);
      send_slot(9'd1, 8'd255, 1'b0);
      send_slot(9'd1, 8'd0, 1'b0);
      send_slot(9'd2, 8'd128, 1'b0);
      send_slot(9'd2, 8'd129, 1'b0);
      send_slot(9'd2, 8'd128, 1'b0);
      send_slot(9'd2, 8'd129, 1'b1);
      end_burst();
      drain();
      write_reg(CSR_CONTROL_BLOCK, 10'd15);
      write_reg(CSR_MIN_CHANGE_SUM, 10'd0);
      send_slot(9'd1, 8'd5, 1'b0);
      send_slot(9'd177, 8'd9, 1'b1);
      end_burst();
      drain();
   endtask

   // random frames, mostly control block slots with clustered values
   task automatic test_random_traffic(input int gap, input int stall,
                                      input logic [CSR_DATA_W-1:0] ctrl,
                                      input logic [CSR_DATA_W-1:0] thresh,
                                      input int items);
      int remaining;
      int frame_len;
      int pick;
      int ch;
      logic [SLOT_W-1:0]  s;
      logic [VALUE_W-1:0] v;
      write_reg(CSR_CONTROL_BLOCK, ctrl);
      write_reg(CSR_MIN_CHANGE_SUM, thresh);
      gap_pct   = gap;
      stall_pct = stall;
      remaining = items;
      while (remaining > 0) begin
         frame_len = $urandom_range(1, 24);
         if (frame_len > remaining) frame_len = remaining;
         for (int k = 0; k < frame_len; k++) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
               ch = $urandom_range(1) ? $urandom_range(3) : $urandom_range(CHANNELS - 1);
               if (ctrl_blk < NUM_BLOCKS) s = SLOT_W'(ctrl_blk * CHANNELS + 1 + ch);
               else s = SLOT_W'($urandom_range(1, NUM_BLOCKS * CHANNELS));
            end else if (pick < 82) begin
               s = SLOT_W'($urandom_range(1, ACTIVE_BLOCKS * CHANNELS));
            end else if (pick < 90) begin
               s = SLOT_W'($urandom_range(ACTIVE_BLOCKS * CHANNELS + 1,
                                          NUM_BLOCKS * CHANNELS));
            end else if (pick < 95) begin
               s = '0;
            end else begin
               s = SLOT_W'($urandom_range(NUM_BLOCKS * CHANNELS + 1, 511));
            end
            pick = $urandom_range(99);
            if (pick < 25) v = VALUE_W'($urandom_range(3));
            else if (pick < 40) v = '0;
            else if (pick < 50) v = '1;
            else v = VALUE_W'($urandom_range(255));
            send_slot(s, v, k == frame_len - 1);
         end
         remaining -= frame_len;
      end
      end_burst();
      drain();
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req.valid      = 1'b0;
      req.slot       = '0;
      req.slot_value = '0;
      req.frame_end  = 1'b0;
      csr_write_en   = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      gap_pct        = 0;
      stall_pct      = 0;
      for (int j = 0; j < CHANNELS; j++) begin
         held_level[j] = '0;
         for (int d = 0; d < HIST_DEPTH; d++) slot_hist[j][d] = '0;
      end
      frame_act = '0;
      ctrl_blk  = CTRL_BLK_RESET;
      min_sum   = MIN_SUM_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_start_code_report();
      test_slot_decode();
      test_threshold_extremes();
      test_random_traffic(0, 0, 10'd11, 10'd2, 75);
      test_random_traffic(88, 0, 10'd0, 10'd0, 75);
      test_random_traffic(0, 88, 10'($urandom_range(1, 10)),
                          10'($urandom_range(0, 60)), 75);
      test_random_traffic(11, 11, 10'd6, 10'd765, 75);
      test_random_traffic(11, 11, 10'd15, 10'd0, 75);
      test_random_traffic(0, 0, 10'($urandom_range(0, 11)),
                          10'($urandom_range(0, 200)), 75);

      if (mismatch_count == 0 && report_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // hang guard
   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
